// ----- design/wlpm_pkg.sv -----
// ----------------------------------------------------------------------------
// wlpm_pkg
// Shared constants and types of the window latency percentile monitor.
// ----------------------------------------------------------------------------
package wlpm_pkg;

    // The ring depth must be a power of two.
    localparam int RING_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int TIME_W     = 64;
    localparam int LAT_W      = 32;
    localparam int QD_W       = 12;
    localparam int MEM_W      = TIME_W + LAT_W;
    localparam int BIT_W      = $clog2(LAT_W);

    // Rank arithmetic: floor(99 * (k - 1) / 100) by a reciprocal multiply.
    localparam int NUM_W      = $clog2(99 * RING_DEPTH);
    localparam int DIV_SHIFT  = NUM_W + 1;
    localparam longint DIV_RECIP = (64'd1 << DIV_SHIFT) / 100;
    localparam int RECIP_W    = DIV_SHIFT - 6;
    localparam int PROD_W     = NUM_W + RECIP_W;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_SLO    = 2'd1;
    localparam logic [1:0] REG_MIN    = 2'd2;
    localparam logic [1:0] REG_QLIM   = 2'd3;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic [31:0]      window_length_ns;
        logic [31:0]      slo_limit_ns;
        logic [CNT_W-1:0] min_window_samples;
        logic [QD_W-1:0]  queue_depth_limit;
    } t_cfg;

    typedef struct packed {
        logic latch;
        logic rec;
        logic scan_inc;
        logic rank_mul;
        logic rank_div;
        logic rank_fix;
        logic sel_chk;
        logic sel_bit;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic scan_end;
        logic in_window;
        logic report;
        logic sel_end;
        logic bit_last;
        logic out_free;
    } t_sts;

endpackage

// ----- design/wlpm_if.sv -----
// ----------------------------------------------------------------------------
// wlpm_in_if / wlpm_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface wlpm_in_if import wlpm_pkg::*;;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [TIME_W-1:0]  time_now_ns;
    logic [TIME_W-1:0]  start_time_ns;
    logic [QD_W-1:0]    queue_depth;

    modport source(output valid, operation, time_now_ns, start_time_ns, queue_depth,
                   input ready);
    modport sink(input valid, operation, time_now_ns, start_time_ns, queue_depth,
                 output ready);
endinterface

interface wlpm_out_if import wlpm_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LAT_W-1:0]   percentile_ns;
    logic               slo_violated;
    logic [CNT_W-1:0]   window_count;

    modport source(output valid, percentile_ns, slo_violated, window_count,
                   input ready);
    modport sink(input valid, percentile_ns, slo_violated, window_count,
                 output ready);
endinterface

// ----- design/wlpm_ram.sv -----
// ----------------------------------------------------------------------------
// wlpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/wlpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// wlpm_ctrl
// Sequencer for record, window scan, rank and bitwise selection phases.
// ----------------------------------------------------------------------------
module wlpm_ctrl import wlpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_REC   = 4'd1;
    localparam logic [3:0] ST_SRD   = 4'd2;
    localparam logic [3:0] ST_SCHK  = 4'd3;
    localparam logic [3:0] ST_RMUL  = 4'd4;
    localparam logic [3:0] ST_RDIV  = 4'd5;
    localparam logic [3:0] ST_RFIX  = 4'd6;
    localparam logic [3:0] ST_SELRD = 4'd7;
    localparam logic [3:0] ST_SELCK = 4'd8;
    localparam logic [3:0] ST_SELBT = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;
    localparam logic [3:0] ST_DISP  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DISP;
                end
            end
            ST_DISP: begin
                n_state = i_sts.is_query ? ST_SRD : ST_REC;
            end
            ST_REC: begin
                o_cmd.rec = 1'b1;
                n_state   = ST_DONE;
            end
            ST_SRD: begin
                n_state = i_sts.scan_end ? ST_RMUL : ST_SCHK;
            end
            ST_SCHK: begin
                if (i_sts.in_window) begin
                    o_cmd.scan_inc = 1'b1;
                    n_state        = ST_SRD;
                end else begin
                    n_state = ST_RMUL;
                end
            end
            ST_RMUL: begin
                o_cmd.rank_mul = 1'b1;
                n_state        = ST_RDIV;
            end
            ST_RDIV: begin
                o_cmd.rank_div = 1'b1;
                n_state        = ST_RFIX;
            end
            ST_RFIX: begin
                o_cmd.rank_fix = 1'b1;
                n_state        = i_sts.report ? ST_SELRD : ST_DONE;
            end
            ST_SELRD: begin
                n_state = i_sts.sel_end ? ST_SELBT : ST_SELCK;
            end
            ST_SELCK: begin
                o_cmd.sel_chk = 1'b1;
                n_state       = ST_SELRD;
            end
            ST_SELBT: begin
                o_cmd.sel_bit = 1'b1;
                n_state       = i_sts.bit_last ? ST_DONE : ST_SELRD;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- design/wlpm_dp.sv -----
// ----------------------------------------------------------------------------
// wlpm_dp
// Sample ring, window scan counters, rank arithmetic and radix selection.
// ----------------------------------------------------------------------------
module wlpm_dp import wlpm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    wlpm_in_if.sink  i_in,
    wlpm_out_if.source o_out
);
    logic              r_op;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_start;
    logic [QD_W-1:0]   r_qdepth;
    logic [TIME_W-1:0] r_cutoff;
    logic [ADDR_W-1:0] r_wp;
    logic [CNT_W-1:0]  r_nvalid;
    logic [CNT_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_k;
    logic [NUM_W-1:0]  r_num;
    logic [CNT_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic [LAT_W-1:0]  r_prefix;
    logic [BIT_W-1:0]  r_bit;
    logic              r_out_valid;
    logic [LAT_W-1:0]  r_out_pct;
    logic              r_out_viol;
    logic [CNT_W-1:0]  r_out_cnt;

    logic [MEM_W-1:0]  w_rdata;
    logic [TIME_W-1:0] w_rtime;
    logic [LAT_W-1:0]  w_rlat;
    logic [ADDR_W-1:0] w_raddr;
    logic [TIME_W-1:0] w_diff;
    logic [LAT_W-1:0]  w_lat;
    logic [PROD_W-1:0] w_prod;
    logic [NUM_W-1:0]  w_rem;
    logic [LAT_W-1:0]  w_mask;
    logic              w_match;

    assign w_rtime = w_rdata[MEM_W-1:LAT_W];
    assign w_rlat  = w_rdata[LAT_W-1:0];
    assign w_raddr = r_wp - ADDR_W'(1) - r_idx[ADDR_W-1:0];

    assign w_diff = r_now - r_start;
    always_comb begin
        if (r_now <= r_start) begin
            w_lat = '0;
        end else if (w_diff[TIME_W-1:LAT_W] != '0) begin
            w_lat = '1;
        end else begin
            w_lat = w_diff[LAT_W-1:0];
        end
    end

    assign w_prod = PROD_W'(r_num) * PROD_W'(DIV_RECIP);
    assign w_rem  = r_num - NUM_W'(r_q) * NUM_W'(100);

    assign w_mask  = LAT_W'({1'b1, {LAT_W{1'b1}}} << ({1'b0, r_bit} + (BIT_W + 1)'(1)));
    assign w_match = (((w_rlat ^ r_prefix) & w_mask) == '0) && !w_rlat[r_bit];

    wlpm_ram #(
        .WIDTH(MEM_W),
        .DEPTH(RING_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.rec),
        .i_waddr(r_wp),
        .i_wdata({r_now, w_lat}),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_sts.is_query  = (r_op == OP_QUERY);
    assign o_sts.scan_end  = (r_idx == r_nvalid);
    assign o_sts.in_window = (w_rtime >= r_cutoff);
    assign o_sts.report    = (r_k != '0) && (r_k >= i_cfg.min_window_samples);
    assign o_sts.sel_end   = (r_idx == r_k);
    assign o_sts.bit_last  = (r_bit == '0);
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_in.operation;
            r_now    <= i_in.time_now_ns;
            r_start  <= i_in.start_time_ns;
            r_qdepth <= i_in.queue_depth;
            r_cutoff <= i_in.time_now_ns - TIME_W'(i_cfg.window_length_ns);
            r_idx    <= '0;
            r_k      <= '0;
            r_prefix <= '0;
        end
        if (i_cmd.scan_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.rank_mul) begin
            r_k   <= r_idx;
            r_num <= NUM_W'(r_idx - CNT_W'(1)) * NUM_W'(99);
        end
        if (i_cmd.rank_div) begin
            r_q <= CNT_W'(w_prod >> DIV_SHIFT);
        end
        if (i_cmd.rank_fix) begin
            if (w_rem >= NUM_W'(100)) begin
                r_q <= r_q + CNT_W'(1);
            end
            r_prefix <= '0;
            r_bit    <= BIT_W'(LAT_W - 1);
            r_idx    <= '0;
            r_cnt    <= '0;
        end
        if (i_cmd.sel_chk) begin
            r_idx <= r_idx + CNT_W'(1);
            if (w_match) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.sel_bit) begin
            if (r_q >= r_cnt) begin
                r_prefix[r_bit] <= 1'b1;
                r_q             <= r_q - r_cnt;
            end
            r_bit <= r_bit - BIT_W'(1);
            r_idx <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.push) begin
            r_out_pct  <= r_prefix;
            r_out_cnt  <= r_k;
            r_out_viol <= (r_op == OP_QUERY) &&
                          ((r_qdepth > i_cfg.queue_depth_limit) ||
                           (r_prefix > i_cfg.slo_limit_ns));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_nvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.rec) begin
                r_wp <= r_wp + ADDR_W'(1);
                if (r_nvalid != CNT_W'(RING_DEPTH)) begin
                    r_nvalid <= r_nvalid + CNT_W'(1);
                end
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.percentile_ns = r_out_pct;
    assign o_out.slo_violated  = r_out_viol;
    assign o_out.window_count  = r_out_cnt;
endmodule

// ----- design/window_latency_percentile_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// window_latency_percentile_monitor_unit
// Sliding-window 99th-percentile latency monitor with an APB register port.
// ----------------------------------------------------------------------------
// A record writes one entry of the single-port-read sample ring and then
// passes its result to the output register. A query first walks the ring from
// the newest sample while samples are in the window, then computes the rank in
// a multiply, a divide and a correction step and, if the window holds at least
// one and at least min_window_samples samples, finds the percentile bit by bit
// in 32 passes over the k window samples. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
module window_latency_percentile_monitor_unit import wlpm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wlpm_in_if.sink     i_in,
    wlpm_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg r_cfg;
    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;

    assign pready     = 1'b1;
    assign i_in.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_length_ns   <= 32'd2000000;
            r_cfg.slo_limit_ns       <= 32'd5000000;
            r_cfg.min_window_samples <= CNT_W'(50);
            r_cfg.queue_depth_limit  <= QD_W'(57);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WINDOW: r_cfg.window_length_ns   <= pwdata;
                REG_SLO:    r_cfg.slo_limit_ns       <= pwdata;
                REG_MIN:    r_cfg.min_window_samples <= pwdata[CNT_W-1:0];
                REG_QLIM:   r_cfg.queue_depth_limit  <= pwdata[QD_W-1:0];
                default:    r_cfg.window_length_ns   <= r_cfg.window_length_ns;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW: prdata = r_cfg.window_length_ns;
            REG_SLO:    prdata = r_cfg.slo_limit_ns;
            REG_MIN:    prdata = 32'(r_cfg.min_window_samples);
            REG_QLIM:   prdata = 32'(r_cfg.queue_depth_limit);
            default:    prdata = '0;
        endcase
    end

    wlpm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_in.valid),
        .o_ready(w_ready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    wlpm_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts),
        .i_in   (i_in),
        .o_out  (o_out)
    );
endmodule
